// File: rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants for the quadratic-probe hash table core.
// ----------------------------------------------------------------------------
package qph_pkg;

	// field widths
	localparam int CMD_W  = 2;
	localparam int KEY_W  = 31;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 4;

	// stored word: key plus an empty flag in the top bit
	localparam int WORD_W = KEY_W + 1;

	// default table size
	localparam int DEF_TABLE_SLOTS = 16;

	// home-slot reduction: key bits folded per cycle
	localparam int MOD_DIGITS = 4;

	// depth of the queue between front and back
	localparam int DEF_QUEUE_DEPTH = 2;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_FIND   = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_MISSING = 2'd2;

	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
	} item_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIVIDE,
		FE_HOLD
	} fe_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PROBE
	} bk_state_t;

endpackage

// File: rtl/qph_front.sv
// ----------------------------------------------------------------------------
// qph_front
// Accepts commands and reduces each key to its home slot, key mod
// TABLE_SLOTS, a few bits per cycle, then hands the word to the queue.
// ----------------------------------------------------------------------------
module qph_front #(
	parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  qph_pkg::cmd_t                    cmd,
	input  logic [qph_pkg::KEY_W-1:0]        key,
	input  logic                             blocked,
	output logic                             busy,
	input  logic                             q_full,
	output logic                             push,
	output qph_pkg::item_t                   item,
	output logic [$clog2(TABLE_SLOTS)-1:0]   home
);
	import qph_pkg::*;

	localparam int AW      = $clog2(TABLE_SLOTS);
	localparam int KPAD_W  = KEY_W + 1;
	localparam int MOD_CYC = KPAD_W / MOD_DIGITS;
	localparam int CNT_W   = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

	fe_state_t          state_q, state_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic [KPAD_W-1:0]  sh_q;
	logic [AW-1:0]      rem_q, rem_nx;
	item_t              item_q;
	logic               accept;
	logic               last_digit;

	assign accept     = start && !busy;
	assign last_digit = (cnt_q == CNT_W'(MOD_CYC - 1));

	// fold the next group of key bits into the running remainder
	always_comb begin
		logic [AW:0] t;
		logic [AW-1:0] r;
		r = rem_q;
		for (int j = 0; j < MOD_DIGITS; j++) begin
			t = {r, sh_q[KPAD_W-1-j]};
			if (t >= (AW+1)'(TABLE_SLOTS)) begin
				t = t - (AW+1)'(TABLE_SLOTS);
			end
			r = t[AW-1:0];
		end
		rem_nx = r;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			FE_IDLE: begin
				if (accept) begin
					state_nx = FE_DIVIDE;
				end
			end
			FE_DIVIDE: begin
				if (last_digit) begin
					state_nx = FE_HOLD;
				end
			end
			FE_HOLD: begin
				if (!q_full) begin
					state_nx = FE_IDLE;
				end
			end
			default: state_nx = FE_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		case (state_q)
			FE_IDLE:   busy = blocked;
			FE_DIVIDE: busy = 1'b1;
			FE_HOLD:   push = !q_full;
			default:   busy = 1'b1;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == FE_DIVIDE) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// capture the command and shift key bits through the reduction
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd <= cmd;
			item_q.key <= key;
			sh_q       <= {1'b0, key};
			rem_q      <= '0;
		end else if (state_q == FE_DIVIDE) begin
			sh_q  <= sh_q << MOD_DIGITS;
			rem_q <= rem_nx;
		end
	end

	assign item = item_q;
	assign home = rem_q;

endmodule

// File: rtl/qph_queue.sv
// ----------------------------------------------------------------------------
// qph_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module qph_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = qph_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] rdata
);
	import qph_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] buf_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = buf_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= wdata;
		end
	end

endmodule

// File: rtl/qph_back.sv
// ----------------------------------------------------------------------------
// qph_back
// Slot memory and probe engine: walks the quadratic probe sequence one slot
// per cycle, inserts, finds or clears, and strobes one result per command.
// ----------------------------------------------------------------------------
module qph_back #(
	parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  qph_pkg::item_t                   q_item,
	input  logic [$clog2(TABLE_SLOTS)-1:0]   q_home,
	output logic                             pop,
	output logic                             clearing,
	output logic                             done,
	output qph_pkg::status_t                 status,
	output logic [qph_pkg::SLOT_W-1:0]       slot
);
	import qph_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int IW = $clog2(TABLE_SLOTS + 1);

	logic [WORD_W-1:0] mem [TABLE_SLOTS];

	bk_state_t         state_q, state_nx;
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     pos_q, step_q, clr_q, addr_s1;
	logic [IW-1:0]     issued_q;
	logic              chk_s1;
	logic [WORD_W-1:0] rd_s1;

	logic [AW:0]       pos_sum, step_sum;
	logic [AW-1:0]     pos_nx, step_nx;
	logic              issue, hit, exhaust, cmd_ok;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic              res_fire;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              res_vld_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;

	// next probe position (home + i*i) and odd step (2i+1), both mod size
	always_comb begin
		pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
		step_sum = {1'b0, step_q} + (AW+1)'(2);
		pos_nx   = (pos_sum >= (AW+1)'(TABLE_SLOTS))
			? AW'(pos_sum - (AW+1)'(TABLE_SLOTS)) : pos_sum[AW-1:0];
		step_nx  = (step_sum >= (AW+1)'(TABLE_SLOTS))
			? AW'(step_sum - (AW+1)'(TABLE_SLOTS)) : step_sum[AW-1:0];
	end

	// judge the slot read for the previous probe
	assign cmd_ok  = (q_item.cmd == CMD_INSERT) || (q_item.cmd == CMD_FIND)
		|| (q_item.cmd == CMD_DELETE);
	assign hit     = chk_s1 && ((cmd_q == CMD_INSERT) ? rd_s1[KEY_W]
		: (rd_s1 == {1'b0, key_q}));
	assign exhaust = chk_s1 && !hit && (issued_q == IW'(TABLE_SLOTS));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == AW'(TABLE_SLOTS - 1)) begin
					state_nx = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid && cmd_ok) begin
					state_nx = BK_PROBE;
				end
			end
			BK_PROBE: begin
				if (hit || exhaust) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// outputs: queue pop, memory write, result
	always_comb begin
		pop        = 1'b0;
		clearing   = 1'b0;
		issue      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = addr_s1;
		mem_wd     = EMPTY_WORD;
		res_fire   = 1'b0;
		res_status = ST_MISSING;
		res_slot   = '0;
		case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
				mem_wa   = clr_q;
			end
			BK_IDLE: begin
				pop = q_valid;
				// an unused command answers at once
				res_fire = q_valid && !cmd_ok;
			end
			BK_PROBE: begin
				issue = (issued_q != IW'(TABLE_SLOTS));
				if (hit) begin
					res_fire   = 1'b1;
					res_status = ST_OK;
					res_slot   = SLOT_W'(addr_s1);
					mem_we     = (cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE);
					mem_wd     = (cmd_q == CMD_INSERT) ? {1'b0, key_q} : EMPTY_WORD;
				end else if (exhaust) begin
					res_fire   = 1'b1;
					res_status = (cmd_q == CMD_INSERT) ? ST_FULL : ST_MISSING;
				end
			end
			default: begin
				clearing = 1'b1;
			end
		endcase
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[pos_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			issued_q  <= '0;
			chk_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			res_vld_q <= res_fire;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop) begin
				issued_q <= '0;
				chk_s1   <= 1'b0;
			end else if (issue && !hit && !exhaust) begin
				issued_q <= issued_q + 1'b1;
				chk_s1   <= 1'b1;
			end else begin
				chk_s1 <= 1'b0;
			end
		end
	end

	// probe datapath and result word
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= q_item.cmd;
			key_q  <= q_item.key;
			pos_q  <= q_home;
			step_q <= AW'(1);
		end else if (issue) begin
			pos_q   <= pos_nx;
			step_q  <= step_nx;
			addr_s1 <= pos_q;
		end
		if (res_fire) begin
			status_q <= res_status;
			slot_q   <= res_slot;
		end
	end

	assign done   = res_vld_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

// File: rtl/quadratic_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing hash table with quadratic probing: insert, find, delete.
//
//   channel   | handshake          | word
//   ----------+--------------------+------------------------------
//   command   | start high, busy low | cmd, key
//   result    | done strobe, 1 cycle | status, slot
//
// The front reduces the key to its home slot while the back works on the
// previous command, and hands the word over once the queue has room, so busy
// stays high from each accepted word through its hand-over. The back probes
// one slot per cycle from a registered-read slot memory (an unused command is
// answered without a probe), and its result strobes in the cycle after the
// deciding probe is checked; done also waits on any words ahead in the queue.
// After reset a clearing pass writes every slot empty; busy stays high
// throughout. The result side cannot stall.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core #(
	parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  qph_pkg::cmd_t               cmd,
	input  logic [qph_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output qph_pkg::status_t            status,
	output logic [qph_pkg::SLOT_W-1:0]  slot
);
	import qph_pkg::*;

	localparam int AW     = $clog2(TABLE_SLOTS);
	localparam int QW     = $bits(item_t) + AW;

	logic          clearing;
	logic          q_full, q_push, q_pop, q_valid;
	item_t         fe_item, q_item;
	logic [AW-1:0] fe_home, q_home;
	logic [QW-1:0] q_rdata;

	// accept and reduce to home slot
	qph_front #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.key     (key),
		.blocked (clearing),
		.busy    (busy),
		.q_full  (q_full),
		.push    (q_push),
		.item    (fe_item),
		.home    (fe_home)
	);

	// decouple front and back
	qph_queue #(
		.DATA_W(QW),
		.DEPTH (DEF_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({fe_item, fe_home}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign q_item = q_rdata[QW-1:AW];
	assign q_home = q_rdata[AW-1:0];

	// probe engine and slot memory
	qph_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_home   (q_home),
		.pop      (q_pop),
		.clearing (clearing),
		.done     (done),
		.status   (status),
		.slot     (slot)
	);

endmodule
